FILE: hw/rtl/lict_pkg.sv
// Package for the local interrupt controller timer.
// Holds register offsets, command codes, field masks and the result word type.
// Used by lict_core and local_interrupt_controller_timer.
package lict_pkg;

	// command codes
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// register byte offsets
	localparam logic [11:0] OFF_ID    = 12'h020;
	localparam logic [11:0] OFF_EOI   = 12'h0B0;
	localparam logic [11:0] OFF_SVR   = 12'h0F0;
	localparam logic [11:0] OFF_ICRLO = 12'h300;
	localparam logic [11:0] OFF_ICRHI = 12'h310;
	localparam logic [11:0] OFF_LVT   = 12'h320;
	localparam logic [11:0] OFF_INIT  = 12'h380;
	localparam logic [11:0] OFF_CUR   = 12'h390;
	localparam logic [11:0] OFF_DIV   = 12'h3E0;

	// command-low storage: kept bits and delivery pending
	localparam logic [19:0] ICR_KEEP = 20'hCCFFF;
	localparam logic [19:0] ICR_PEND = 20'h01000;

	// reset value of the spurious-vector register (vector 0xFF, disabled)
	localparam logic [8:0] SVR_RESET = 9'h0FF;

	// default width of the timer counters
	localparam int COUNT_BITS_DEF = 32;

	// one result word
	typedef struct packed {
		logic [31:0] read_data;
		logic        timer_fire;
		logic [7:0]  fire_vector;
		logic        ipi_send;
		logic [7:0]  ipi_dest;
		logic [2:0]  ipi_mode;
		logic [7:0]  ipi_vector;
		logic        eoi_done;
	} result_t;

endpackage

FILE: hw/rtl/lict_core.sv
// Register file and countdown timer of the local interrupt controller.
// Applies one bus read, write or tick per step and forms its result word.
// Depends on lict_pkg.
module lict_core #(
	parameter int COUNT_BITS = lict_pkg::COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [1:0]           cmd,
	input  logic [11:0]          offset,
	input  logic [31:0]          wdata,
	input  logic [7:0]           own_id,
	output lict_pkg::result_t    res
);
	import lict_pkg::*;

	logic [8:0]            spurious_q;
	logic [7:0]            cmd_high_dest_q;
	logic [19:0]           cmd_low_q;
	logic [7:0]            lvt_vec_q;
	logic                  lvt_mask_q;
	logic                  lvt_per_q;
	logic [COUNT_BITS-1:0] initial_q;
	logic [COUNT_BITS-1:0] current_q;
	logic [3:0]            divide_q;
	logic [6:0]            prescale_q;

	logic                  sw_en;
	logic                  is_wr;
	logic                  is_tick;
	logic [2:0]            div_code;
	logic [7:0]            ratio;
	logic [7:0]            presc_sum;
	logic                  presc_hit;
	logic                  cur_nz;
	logic [COUNT_BITS-1:0] cur_dec;
	logic                  dec_zero;
	logic [31:0]           rd_mux;

	assign sw_en   = spurious_q[8];
	assign is_wr   = step && (cmd == CMD_WRITE);
	assign is_tick = step && (cmd == CMD_TICK);

	// divided clock: code 7 divides by one, else by 2^(code+1)
	assign div_code  = {divide_q[3], divide_q[1:0]};
	assign ratio     = (div_code == 3'd7) ? 8'd1 : (8'd1 << (div_code + 3'd1));
	assign presc_sum = {1'b0, prescale_q} + 8'd1;
	assign presc_hit = presc_sum >= ratio;
	assign cur_nz    = current_q != '0;
	assign cur_dec   = current_q - COUNT_BITS'(1);
	assign dec_zero  = cur_dec == '0;

	// register read mux
	always_comb begin
		case (offset)
			OFF_ID:    rd_mux = {own_id, 24'd0};
			OFF_SVR:   rd_mux = {23'd0, spurious_q};
			OFF_ICRLO: rd_mux = {12'd0, cmd_low_q};
			OFF_ICRHI: rd_mux = {cmd_high_dest_q, 24'd0};
			OFF_LVT:   rd_mux = {14'd0, lvt_per_q, lvt_mask_q, 8'd0, lvt_vec_q};
			OFF_INIT:  rd_mux = 32'(initial_q);
			OFF_CUR:   rd_mux = 32'(current_q);
			OFF_DIV:   rd_mux = {28'd0, divide_q};
			default:   rd_mux = 32'd0;
		endcase
	end

	// form the result word of this step
	always_comb begin
		res = '0;
		case (cmd)
			CMD_READ: begin
				res.read_data = rd_mux;
			end
			CMD_WRITE: begin
				if (offset == OFF_EOI) begin
					res.eoi_done = 1'b1;
				end
				if (offset == OFF_ICRLO) begin
					res.ipi_send   = 1'b1;
					res.ipi_dest   = cmd_high_dest_q;
					res.ipi_mode   = wdata[10:8];
					res.ipi_vector = wdata[7:0];
				end
			end
			CMD_TICK: begin
				if (cur_nz && presc_hit && dec_zero && !lvt_mask_q && sw_en) begin
					res.timer_fire  = 1'b1;
					res.fire_vector = lvt_vec_q;
				end
			end
			default: res = '0;
		endcase
	end

	// update register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spurious_q      <= SVR_RESET;
			cmd_high_dest_q <= '0;
			cmd_low_q       <= '0;
			lvt_vec_q       <= '0;
			lvt_mask_q      <= 1'b1;
			lvt_per_q       <= 1'b0;
			initial_q       <= '0;
			current_q       <= '0;
			divide_q        <= '0;
			prescale_q      <= '0;
		end else if (is_wr) begin
			case (offset)
				OFF_SVR: begin
					spurious_q <= wdata[8:0];
					if (!wdata[8]) begin
						lvt_mask_q <= 1'b1;
					end
				end
				OFF_ICRLO: cmd_low_q       <= (wdata[19:0] & ICR_KEEP) | ICR_PEND;
				OFF_ICRHI: cmd_high_dest_q <= wdata[31:24];
				OFF_LVT: begin
					lvt_vec_q  <= wdata[7:0];
					lvt_mask_q <= wdata[16] || !sw_en;
					lvt_per_q  <= wdata[17];
				end
				OFF_INIT: begin
					initial_q  <= wdata[COUNT_BITS-1:0];
					current_q  <= wdata[COUNT_BITS-1:0];
					prescale_q <= '0;
				end
				OFF_DIV:   divide_q <= {wdata[3], 1'b0, wdata[1:0]};
				default:   ;
			endcase
		end else if (is_tick) begin
			// drop delivery pending, advance the timer while it runs
			cmd_low_q <= cmd_low_q & ~ICR_PEND;
			if (cur_nz) begin
				if (presc_hit) begin
					prescale_q <= '0;
					if (dec_zero && lvt_per_q) begin
						current_q <= initial_q;
					end else begin
						current_q <= cur_dec;
					end
				end else begin
					prescale_q <= presc_sum[6:0];
				end
			end
		end
	end

endmodule

FILE: hw/rtl/local_interrupt_controller_timer.sv
// Local interrupt controller timer: top level with input and result registers.
// Instantiates lict_core; depends on lict_pkg.
//
// Each input word is a bus read, a bus write or one bus-clock tick and yields
// exactly one result word. A word is latched into the input register, executed
// against the register file and timer once the result register can take it, and
// lands there; one word per cycle is sustained as long as results are taken. The
// result register frees the input side while a finished word waits. The own_id
// register is written through the cfg channel, which is always ready, and should
// only be written while no word is in flight.
module local_interrupt_controller_timer #(
	parameter int COUNT_BITS = lict_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [11:0] offset,
	input  logic [31:0] write_data,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        timer_fire,
	output logic [7:0]  fire_vector,
	output logic        ipi_send,
	output logic [7:0]  ipi_dest,
	output logic [2:0]  ipi_mode,
	output logic [7:0]  ipi_vector,
	output logic        eoi_done,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import lict_pkg::*;

	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [11:0] off_s1;
	logic [31:0] wd_s1;
	logic        out_valid_q;
	result_t     res_q;
	result_t     res_d;
	logic [7:0]  own_id_q;
	logic        adv;
	logic        in_acc;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_acc    = in_valid && !in_stall;

	// hold own_id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			own_id_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= command;
			off_s1 <= offset;
			wd_s1  <= write_data;
		end
	end

	lict_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.cmd    (cmd_s1),
		.offset (off_s1),
		.wdata  (wd_s1),
		.own_id (own_id_q),
		.res    (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = res_q.read_data;
	assign timer_fire  = res_q.timer_fire;
	assign fire_vector = res_q.fire_vector;
	assign ipi_send    = res_q.ipi_send;
	assign ipi_dest    = res_q.ipi_dest;
	assign ipi_mode    = res_q.ipi_mode;
	assign ipi_vector  = res_q.ipi_vector;
	assign eoi_done    = res_q.eoi_done;

endmodule
